// ===== rtl/bia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg: shared types and constants for the body-to-inertial rotation core
// Fixed-point widths, CORDIC arctangent table, cell bus type, latency.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;

    localparam int ACCEL_W  = 24;   // Q15.8 inputs and gravity
    localparam int ANGLE_W  = 16;   // Q2.13 radians
    localparam int OUT_W    = 26;   // Q17.8 outputs
    localparam int XY_W     = 33;   // CORDIC x/y, Q30
    localparam int Z_W      = 34;   // CORDIC residual angle, Q30
    localparam int ATAN_W   = 31;
    localparam int SHIFT_W  = $clog2(ATAN_ENTRIES);
    localparam int PROD_W   = ACCEL_W + XY_W;
    localparam int ACC_W    = 58;
    localparam int FRAC_SH  = 30;
    localparam int ANGLE_SH = 17;   // Q13 to Q30

    // input register + cells + four post stages
    localparam int LATENCY  = NUM_CELLS + 5;

    localparam logic signed [Z_W-1:0]     Q30_PI       = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]     Q30_HALF_PI  = 34'sd1686629713;
    localparam logic signed [XY_W-1:0]    CORDIC_GAIN0 = 33'sd652032874;
    localparam logic signed [ACCEL_W-1:0] GRAVITY_RESET = 24'sd2529;
    localparam logic signed [ACC_W-1:0]   ROUND_BIAS   = 58'sd536870912;
    localparam logic signed [ACC_W-1:0]   OUT_MAX      = 58'sd33554431;
    localparam logic signed [ACC_W-1:0]   OUT_MIN      = -58'sd33554432;

    localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76,
        31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD,
        31'h000FFFFF, 31'h0007FFFF, 31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF,
        31'h00007FFF, 31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
        31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F
    };

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [Z_W-1:0]     z;
        logic                      flip;
        logic signed [ACCEL_W-1:0] ax;
        logic signed [ACCEL_W-1:0] az;
    } cordic_bus_t;

endpackage

// ===== rtl/bia_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotate x/y by +-atan(2^-i), update residual angle, pass operands along.
// ----------------------------------------------------------------------------
module bia_cordic_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bia_pkg::SHIFT_W-1:0] shift_amt,
    input  logic [bia_pkg::ATAN_W-1:0]  atan_val,
    input  logic                        in_valid,
    input  bia_pkg::cordic_bus_t        bus_in,
    output logic                        out_valid,
    output bia_pkg::cordic_bus_t        bus_out
);
    import bia_pkg::*;

    logic                  valid_reg;
    cordic_bus_t           bus_reg;
    cordic_bus_t           bus_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  atan_ext;

    always_comb
    begin
        xs       = bus_in.x >>> shift_amt;
        ys       = bus_in.y >>> shift_amt;
        atan_ext = $signed({{(Z_W-ATAN_W){1'b0}}, atan_val});
        bus_next = bus_in;
        // non-negative residual rotates positive
        if (!bus_in.z[Z_W-1])
        begin
            bus_next.x = bus_in.x - ys;
            bus_next.y = bus_in.y + xs;
            bus_next.z = bus_in.z - atan_ext;
        end
        else
        begin
            bus_next.x = bus_in.x + ys;
            bus_next.y = bus_in.y - xs;
            bus_next.z = bus_in.z + atan_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    assign out_valid = valid_reg;
    assign bus_out   = bus_reg;

endmodule

// ===== rtl/bia_combine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_combine: project body acceleration onto sin/cos and finish the result
// Four products, pairwise sums, fold sign and gravity, round and saturate.
// ----------------------------------------------------------------------------
module bia_combine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  bia_pkg::cordic_bus_t               bus_in,
    input  logic signed [bia_pkg::ACCEL_W-1:0] gravity,
    output logic                               out_valid,
    output logic signed [bia_pkg::OUT_W-1:0]   out_x,
    output logic signed [bia_pkg::OUT_W-1:0]   out_z
);
    import bia_pkg::*;

    // stage A: products
    logic                     a_valid_reg;
    logic                     a_flip_reg;
    logic signed [PROD_W-1:0] xc_reg, zs_reg, xs_reg, zc_reg;
    // stage B: pairwise sums
    logic                     b_valid_reg;
    logic                     b_flip_reg;
    logic signed [ACC_W-1:0]  tx_reg, tz_reg;
    // stage C: sign fold, gravity, rounding bias
    logic                     c_valid_reg;
    logic signed [ACC_W-1:0]  rx_reg, rz_reg;
    logic signed [ACC_W-1:0]  rx_next, rz_next, grav_q38, fx, fz;
    // stage D: scale and saturate
    logic                     d_valid_reg;
    logic signed [OUT_W-1:0]  ox_reg, oz_reg;
    logic signed [ACC_W-1:0]  qx, qz;
    logic signed [OUT_W-1:0]  ox_next, oz_next;

    always_comb
    begin
        grav_q38 = $signed({{(ACC_W-ACCEL_W-FRAC_SH){gravity[ACCEL_W-1]}},
                            gravity, {FRAC_SH{1'b0}}});
        fx       = b_flip_reg ? -tx_reg : tx_reg;
        fz       = b_flip_reg ? -tz_reg : tz_reg;
        rx_next  = fx + ROUND_BIAS;
        rz_next  = fz + grav_q38 + ROUND_BIAS;

        qx = rx_reg >>> FRAC_SH;
        qz = rz_reg >>> FRAC_SH;
        if (qx > OUT_MAX)
            ox_next = OUT_W'(OUT_MAX);
        else if (qx < OUT_MIN)
            ox_next = OUT_W'(OUT_MIN);
        else
            ox_next = OUT_W'(qx);
        if (qz > OUT_MAX)
            oz_next = OUT_W'(OUT_MAX);
        else if (qz < OUT_MIN)
            oz_next = OUT_W'(OUT_MIN);
        else
            oz_next = OUT_W'(qz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            ox_reg      <= '0;
            oz_reg      <= '0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            // hold the last result between strobes
            if (c_valid_reg)
            begin
                ox_reg <= ox_next;
                oz_reg <= oz_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_flip_reg <= bus_in.flip;
        xc_reg     <= bus_in.ax * bus_in.x;
        zs_reg     <= bus_in.az * bus_in.y;
        xs_reg     <= bus_in.ax * bus_in.y;
        zc_reg     <= bus_in.az * bus_in.x;

        b_flip_reg <= a_flip_reg;
        tx_reg     <= ACC_W'(xc_reg) + ACC_W'(zs_reg);
        tz_reg     <= ACC_W'(zc_reg) - ACC_W'(xs_reg);

        rx_reg     <= rx_next;
        rz_reg     <= rz_next;
    end

    assign out_valid = d_valid_reg;
    assign out_x     = ox_reg;
    assign out_z     = oz_reg;

endmodule

// ===== rtl/body_to_inertial_accel_rotate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_to_inertial_accel_rotate_core: body-frame to inertial-frame rotation
// Rotates a planar body acceleration by the pitch angle and adds gravity.
// ----------------------------------------------------------------------------
// Users: this core takes one transaction per clock (start while busy is low;
// busy never rises) and returns each result as a one-cycle result_valid
// strobe. The receiver cannot stall the core, so capture every strobe. A
// result passes the input register, the chain of CORDIC cells, one
// micro-rotation per cell, and the multiply, sum, gravity and saturation
// stages behind it. Outputs are Q17.8 and saturate; inertial_accel_z
// includes gravity_accel (reset 9.88 m/s^2, Q15.8 value 2529). Write gravity
// through the cfg channel only while no transaction is in flight.
// ----------------------------------------------------------------------------
module body_to_inertial_accel_rotate_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [bia_pkg::ACCEL_W-1:0] body_accel_x,
    input  logic signed [bia_pkg::ACCEL_W-1:0] body_accel_z,
    input  logic signed [bia_pkg::ANGLE_W-1:0] attitude_angle,
    output logic                               result_valid,
    output logic signed [bia_pkg::OUT_W-1:0]   inertial_accel_x,
    output logic signed [bia_pkg::OUT_W-1:0]   inertial_accel_z,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic signed [bia_pkg::ACCEL_W-1:0] cfg_data
);
    import bia_pkg::*;

    logic signed [ACCEL_W-1:0] gravity_reg;
    logic                      in_valid_reg;
    cordic_bus_t               in_bus_reg;
    cordic_bus_t               in_bus_next;
    logic signed [Z_W-1:0]     z_raw;

    logic                      cell_valid [NUM_CELLS+1];
    cordic_bus_t               cell_bus   [NUM_CELLS+1];

    // The pipeline never stalls, so a transaction is taken on every start.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Gravity register: the one configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gravity_reg <= GRAVITY_RESET;
        else if (cfg_valid && cfg_ready)
            gravity_reg <= cfg_data;
    end

    // Widen the angle to Q30 and fold it into +-pi/2; the fold flips the
    // sign of both sin and cos, which the combine stage applies.
    always_comb
    begin
        z_raw = $signed({{(Z_W-ANGLE_W-ANGLE_SH){attitude_angle[ANGLE_W-1]}},
                         attitude_angle, {ANGLE_SH{1'b0}}});
        in_bus_next.x    = CORDIC_GAIN0;
        in_bus_next.y    = '0;
        in_bus_next.ax   = body_accel_x;
        in_bus_next.az   = body_accel_z;
        in_bus_next.z    = z_raw;
        in_bus_next.flip = 1'b0;
        if (z_raw > Q30_HALF_PI)
        begin
            in_bus_next.z    = z_raw - Q30_PI;
            in_bus_next.flip = 1'b1;
        end
        else if (z_raw < -Q30_HALF_PI)
        begin
            in_bus_next.z    = z_raw + Q30_PI;
            in_bus_next.flip = 1'b1;
        end
    end

    // Input register: capture each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_bus_reg <= in_bus_next;
    end

    assign cell_valid[0] = in_valid_reg;
    assign cell_bus[0]   = in_bus_reg;

    // Chain of micro-rotation cells; cell i shifts by i.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        bia_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_amt (SHIFT_W'(i)),
            .atan_val  (ATAN_TABLE[i]),
            .in_valid  (cell_valid[i]),
            .bus_in    (cell_bus[i]),
            .out_valid (cell_valid[i+1]),
            .bus_out   (cell_bus[i+1])
        );
    end

    // Project, add gravity, round and saturate.
    bia_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_valid[NUM_CELLS]),
        .bus_in    (cell_bus[NUM_CELLS]),
        .gravity   (gravity_reg),
        .out_valid (result_valid),
        .out_x     (inertial_accel_x),
        .out_z     (inertial_accel_z)
    );

endmodule

// ===== rtl/bia_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_checker: port-level assertions for the rotation core
// Throughput, latency, output hold and cfg acceptance checks, bound to the top level.
// ----------------------------------------------------------------------------
module bia_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               result_valid,
    input logic signed [bia_pkg::OUT_W-1:0]   inertial_accel_x,
    input logic signed [bia_pkg::OUT_W-1:0]   inertial_accel_z,
    input logic                               cfg_valid,
    input logic                               cfg_ready
);
    import bia_pkg::*;

    // The pipeline takes a transaction every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a non-stalling pipeline");

    // Every result strobe traces back to an accepted transaction.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching transaction");

    // Hold result values between strobes.
    a_hold_x: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |=> (result_valid || $stable(inertial_accel_x)))
        else $error("inertial_accel_x changed without a strobe");

    a_hold_z: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |=> (result_valid || $stable(inertial_accel_z)))
        else $error("inertial_accel_z changed without a strobe");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg write stalled");

endmodule

bind body_to_inertial_accel_rotate_core bia_checker u_bia_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .result_valid     (result_valid),
    .inertial_accel_x (inertial_accel_x),
    .inertial_accel_z (inertial_accel_z),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready)
);

// ===== sim/body_to_inertial_accel_rotate_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_to_inertial_accel_rotate_core_tb: self-checking bench for the rotator
// Drives body accelerations and pitch angles through the start/busy port,
// rebuilds every rotated vector with a bit-exact CORDIC predictor and checks
// each result_valid strobe against the oldest pending prediction. Gravity is
// rewritten in the gravity and random tests, with the rotator drained, through the cfg channel.
// ----------------------------------------------------------------------------
module body_to_inertial_accel_rotate_core_tb;

    import bia_pkg::ACCEL_W;
    import bia_pkg::ANGLE_W;
    import bia_pkg::OUT_W;
    import bia_pkg::LATENCY;
    import bia_pkg::CORDIC_STAGES;

    // Constants of the rotation; fixed-point values in Q30 but the Q8 saturation limits
    localparam longint PI_Q30        = 64'sd3373259426;
    localparam longint HALF_PI_Q30   = 64'sd1686629713;
    localparam longint INV_GAIN_Q30  = 64'sd652032874;
    localparam longint ROUND_HALF    = 64'sd536870912;
    localparam longint SAT_HIGH      = 64'sd33554431;
    localparam longint SAT_LOW       = -64'sd33554432;
    localparam int     ARCTAN_COUNT  = 24;
    localparam int     FRAC_BITS     = 30;
    localparam int     ANGLE_TO_Q30  = 131072;      // Q13 to Q30 scale
    localparam int     MAX_IDLE      = 17;
    localparam int     STALL_LIMIT   = 4000;
    localparam int     RANDOM_ITEMS  = 1050;

    localparam logic signed [ACCEL_W-1:0] GRAVITY_AT_RESET = 24'sd2529;
    localparam logic signed [ACCEL_W-1:0] ACCEL_MAX = 24'sh7FFFFF;
    localparam logic signed [ACCEL_W-1:0] ACCEL_MIN = 24'sh800000;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sh7FFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 16'sh8000;
    // pi/2 and pi in Q2.13, both just below the true value
    localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 16'sd12867;
    localparam logic signed [ANGLE_W-1:0] ANGLE_PI      = 16'sd25735;

    typedef struct {
        logic signed [OUT_W-1:0] accel_x;
        logic signed [OUT_W-1:0] accel_z;
    } inertial_accel_t;

    // Truncated arctangent table, Q30 radians
    longint arctan_q30 [ARCTAN_COUNT] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [ACCEL_W-1:0]   body_accel_x;
    logic signed [ACCEL_W-1:0]   body_accel_z;
    logic signed [ANGLE_W-1:0]   attitude_angle;
    logic                        result_valid;
    logic signed [OUT_W-1:0]     inertial_accel_x;
    logic signed [OUT_W-1:0]     inertial_accel_z;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic signed [ACCEL_W-1:0]   cfg_data;

    // Predictor copy of the gravity register and the queue of rotated vectors
    logic signed [ACCEL_W-1:0]   gravity_setting;
    inertial_accel_t             pending_accel [$];
    int                          mismatch_count;
    int                          stall_cycles;
    bit                          burst_mode;

    body_to_inertial_accel_rotate_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .body_accel_x     (body_accel_x),
        .body_accel_z     (body_accel_z),
        .attitude_angle   (attitude_angle),
        .result_valid     (result_valid),
        .inertial_accel_x (inertial_accel_x),
        .inertial_accel_z (inertial_accel_z),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round a Q38 sum once to Q8 (add half, floor), then clamp to 26 bits
    function automatic logic signed [OUT_W-1:0] round_to_q8(input longint acc);
        longint r;
        r = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (r > SAT_HIGH)
            r = SAT_HIGH;
        if (r < SAT_LOW)
            r = SAT_LOW;
        return r[OUT_W-1:0];
    endfunction

    // Rotate the body vector by the pitch angle and add gravity to z
    function automatic inertial_accel_t rotate_to_inertial(
        input logic signed [ACCEL_W-1:0] ax_in,
        input logic signed [ACCEL_W-1:0] az_in,
        input logic signed [ANGLE_W-1:0] angle_in,
        input logic signed [ACCEL_W-1:0] gravity_in
    );
        longint          ax;
        longint          az;
        longint          g;
        longint          z;
        longint          cos_q30;
        longint          sin_q30;
        longint          x_shift;
        longint          y_shift;
        bit              flip;
        inertial_accel_t r;
        ax      = ax_in;
        az      = az_in;
        g       = gravity_in;
        z       = longint'(angle_in) * ANGLE_TO_Q30;
        cos_q30 = INV_GAIN_Q30;
        sin_q30 = 0;
        flip    = 1'b0;
        // fold angles beyond +-pi/2 by pi, negate sin and cos afterwards
        if (z > HALF_PI_Q30)
        begin
            z    = z - PI_Q30;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z    = z + PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < ARCTAN_COUNT; i++)
        begin
            x_shift = cos_q30 >>> i;
            y_shift = sin_q30 >>> i;
            if (z >= 0)
            begin
                cos_q30 = cos_q30 - y_shift;
                sin_q30 = sin_q30 + x_shift;
                z       = z - arctan_q30[i];
            end
            else
            begin
                cos_q30 = cos_q30 + y_shift;
                sin_q30 = sin_q30 - x_shift;
                z       = z + arctan_q30[i];
            end
        end
        if (flip)
        begin
            cos_q30 = -cos_q30;
            sin_q30 = -sin_q30;
        end
        r.accel_x = round_to_q8(ax * cos_q30 + az * sin_q30);
        r.accel_z = round_to_q8(-ax * sin_q30 + az * cos_q30 + (g <<< FRAC_BITS));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Compare every strobe with the oldest pending vector
    always @(posedge clk)
    begin
        inertial_accel_t want;
        if (rst_n && result_valid)
        begin
            if (pending_accel.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending x=%0d z=%0d",
                                          inertial_accel_x, inertial_accel_z));
            end
            else
            begin
                want = pending_accel.pop_front();
                if (inertial_accel_x !== want.accel_x)
                    report_mismatch($sformatf("inertial_accel_x got %0d want %0d",
                                              inertial_accel_x, want.accel_x));
                if (inertial_accel_z !== want.accel_z)
                    report_mismatch($sformatf("inertial_accel_z got %0d want %0d",
                                              inertial_accel_z, want.accel_z));
            end
        end
    end

    // Watchdog: count cycles in which no transaction of any kind completes
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one vector; start stays high across back-to-back transactions and
    // drops here only when an idle gap is drawn.
    task automatic send_vector(
        input logic signed [ACCEL_W-1:0] ax,
        input logic signed [ACCEL_W-1:0] az,
        input logic signed [ANGLE_W-1:0] angle
    );
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        body_accel_x   <= ax;
        body_accel_z   <= az;
        attitude_angle <= angle;
        do
            @(posedge clk);
        while (busy);
        pending_accel.push_back(rotate_to_inertial(ax, az, angle, gravity_setting));
    endtask

    // Drop start and hold until every pending vector has come back
    task automatic drain_pipeline;
        start <= 1'b0;
        repeat (LATENCY + 2) @(posedge clk);
        while (pending_accel.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_gravity(input logic signed [ACCEL_W-1:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        gravity_setting = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [ACCEL_W-1:0] pick_accel;
        case ($urandom_range(0, 7))
            0:       return ACCEL_MAX;
            1:       return ACCEL_MIN;
            2:       return ACCEL_W'($urandom_range(0, 2047)) - ACCEL_W'(1024);
            default: return ACCEL_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pick_angle;
        case ($urandom_range(0, 9))
            0:       return ANGLE_HALF_PI + ANGLE_W'($urandom_range(0, 2));
            1:       return -ANGLE_HALF_PI - ANGLE_W'($urandom_range(0, 2));
            2:       return ($urandom_range(0, 1) != 0) ? ANGLE_MAX : ANGLE_MIN;
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of every field, the pi fold edges, reset gravity, a short burst
    task automatic test_directed_vectors;
        burst_mode = 1'b0;
        send_vector(24'sd0, 24'sd0, 16'sd0);
        send_vector(24'sd256, 24'sd0, 16'sd0);
        send_vector(ACCEL_MAX, ACCEL_MAX, 16'sd0);
        send_vector(ACCEL_MIN, ACCEL_MIN, 16'sd0);
        send_vector(ACCEL_MAX, ACCEL_MIN, ANGLE_MAX);
        send_vector(ACCEL_MIN, ACCEL_MAX, ANGLE_MIN);
        send_vector(ACCEL_MAX, ACCEL_MAX, 16'sd6434);       // about pi/4
        send_vector(ACCEL_MIN, ACCEL_MIN, -16'sd6434);
        send_vector(ACCEL_MAX, 24'sd0, ANGLE_HALF_PI);
        send_vector(ACCEL_MAX, 24'sd0, ANGLE_HALF_PI + 16'sd1);
        send_vector(24'sd0, ACCEL_MAX, -ANGLE_HALF_PI);
        send_vector(24'sd0, ACCEL_MAX, -ANGLE_HALF_PI - 16'sd1);
        send_vector(ACCEL_MIN, 24'sd1, ANGLE_PI);
        send_vector(24'sd1, ACCEL_MIN, -ANGLE_PI);
        send_vector(-24'sd1, -24'sd1, -16'sd1);
        send_vector(24'sd1, -24'sd1, 16'sd1);
        // back-to-back transactions
        burst_mode = 1'b1;
        send_vector(24'sh555555, 24'shAAAAAA, 16'sh5555);
        send_vector(24'shAAAAAA, 24'sh555555, 16'shAAAA);
        send_vector(24'sd12345, -24'sd54321, 16'sd1000);
        burst_mode = 1'b0;
    endtask

    // Gravity at its extremes, zero and minus one, then back to reset
    task automatic test_gravity_settings;
        logic signed [ACCEL_W-1:0] grav_values [5];
        grav_values = '{ACCEL_MAX, ACCEL_MIN, 24'sd0, -24'sd1, GRAVITY_AT_RESET};
        foreach (grav_values[k])
        begin
            write_gravity(grav_values[k]);
            send_vector(ACCEL_MAX, ACCEL_MAX, 16'sd0);
            send_vector(ACCEL_MIN, ACCEL_MIN, ANGLE_MAX);
            send_vector(pick_accel(), pick_accel(), pick_angle());
        end
    endtask

    // Long random stream with bursty and gappy segments and gravity changes
    task automatic test_random_stream;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            if (n % 210 == 105)
                write_gravity(($urandom_range(0, 3) == 0) ? pick_accel()
                                                          : ACCEL_W'($urandom));
            send_vector(pick_accel(), pick_accel(), pick_angle());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        body_accel_x    = '0;
        body_accel_z    = '0;
        attitude_angle  = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        gravity_setting = GRAVITY_AT_RESET;
        mismatch_count  = 0;
        stall_cycles    = 0;
        burst_mode      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_vectors();
        test_gravity_settings();
        test_random_stream();

        drain_pipeline();
        repeat (LATENCY + 4) @(posedge clk);
        if (pending_accel.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_accel.size()));
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
